[hw/rtl/eegu_pkg.sv]
// Shared types and constants of the embedding edge gradient update block.
package eegu_pkg;

	localparam int VERTEX_W  = 12;
	localparam int NEGATIVES = 5;
	localparam int COORD_W   = 32;
	localparam int CFG_W     = 24;
	localparam int MUL_STEPS = 32;
	localparam int DIV_STEPS = 42;

	localparam logic [59:0] ONE_Q16   = 60'd65536;
	localparam logic [59:0] TENTH_Q16 = 60'd6554;

	typedef enum logic [1:0] {
		REG_DISTANCE_SCALE   = 2'd0,
		REG_REPULSION_WEIGHT = 2'd1,
		REG_GRADIENT_LIMIT   = 2'd2
	} reg_index_t;

	typedef enum logic {
		OP_MUL = 1'b0,
		OP_DIV = 1'b1
	} arith_op_t;

	typedef struct packed {
		logic      start;
		arith_op_t op;
		logic [63:0] a;
		logic [63:0] b;
	} arith_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] result;
	} arith_rsp_t;

endpackage

[hw/rtl/embedding_edge_gradient_update.sv]
// Top level: embedding memory, update sequencer and output register.
// A load item writes its vertex and emits it. An update item visits the target, then
// each negative in turn, skipping a negative equal to the target, and last writes the source.
// Each partner runs eight products and one or two quotients in turn through the one shared
// bit-serial unit; a stalled result adds its wait. Reset idles the sequencer, clears the
// output valid flag and sets the configuration registers to defaults; the embedding memory
// is not cleared and holds no defined value until a vertex is loaded.
module embedding_edge_gradient_update (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// source_vertex, target_vertex, neg_0..neg_4, step_rate, load_x, load_y, zero pad
	input  logic [167:0] s_axis_tdata,
	// kind
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// vertex, out_x, out_y, zero pad
	output logic [79:0]  m_axis_tdata,
	output logic         m_axis_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [23:0]  cfg_data
);

	typedef enum logic [19:0] {
		ST_IDLE    = 20'd1,
		ST_LOAD    = 20'd2,
		ST_SRC_RD  = 20'd4,
		ST_SRC_CAP = 20'd8,
		ST_SEL     = 20'd16,
		ST_P_RD    = 20'd32,
		ST_P_CAP   = 20'd64,
		ST_SQX     = 20'd128,
		ST_SQY     = 20'd256,
		ST_FH      = 20'd512,
		ST_FL      = 20'd1024,
		ST_T1      = 20'd2048,
		ST_G       = 20'd4096,
		ST_GX      = 20'd8192,
		ST_GY      = 20'd16384,
		ST_AX      = 20'd32768,
		ST_AY      = 20'd65536,
		ST_P_WR    = 20'd131072,
		ST_FIN_RD  = 20'd262144,
		ST_FIN_WR  = 20'd524288
	} state_t;

	state_t state_q;

	logic [23:0] scale_q, gamma_q, limit_q;

	logic [11:0] src_q, tgt_q;
	logic [4:0][11:0] neg_q;
	logic [15:0] alpha_q;
	logic [31:0] load_x_q, load_y_q;

	logic [63:0] mem [4096];
	logic [63:0] rdata_q;
	logic [11:0] raddr;
	logic        we;
	logic [11:0] waddr;
	logic [63:0] wdata;

	logic signed [31:0] cx_q, cy_q, px_q, py_q;
	logic [2:0]  pidx_q;
	logic [11:0] pvtx_q;
	logic [31:0] dxm_q, dym_q;
	logic        dxn_q, dyn_q;
	logic [47:0] sqx_q;
	logic [48:0] sq_q;
	logic [63:0] fh_q;
	logic [59:0] f_q;
	logic [28:0] gmag_q;
	logic        gneg_q;
	logic [23:0] gxm_q, gym_q;
	logic        gxs_q, gys_q;
	logic signed [25:0] ax_q, ay_q;
	logic signed [27:0] ex_q, ey_q;

	logic        out_valid_q, out_last_q;
	logic [11:0] out_vertex_q;
	logic [31:0] out_x_q, out_y_q;
	logic        out_free;

	eegu_pkg::arith_req_t req_q;
	eegu_pkg::arith_rsp_t rsp;
	logic                 arith_go;

	logic signed [32:0] dx_c, dy_c;
	logic [11:0]        sel_vtx;
	logic [59:0]        f_c;
	logic [47:0]        prod_hi;
	logic [23:0]        clip_c;
	logic signed [25:0] a_c;
	logic signed [31:0] nx_c, ny_c, sx_c, sy_c;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		if (v > 34'sd2147483647)
			return 32'sh7FFFFFFF;
		else if (v < -34'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	eegu_arith u_arith (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_q),
		.rsp   (rsp)
	);

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign out_free      = !out_valid_q || m_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {4'd0, out_y_q, out_x_q, out_vertex_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= 24'd65536;
			gamma_q <= 24'd458752;
			limit_q <= 24'd327680;
		end else if (cfg_valid) begin
			case (cfg_index)
				eegu_pkg::REG_DISTANCE_SCALE:   scale_q <= cfg_data;
				eegu_pkg::REG_REPULSION_WEIGHT: gamma_q <= cfg_data;
				eegu_pkg::REG_GRADIENT_LIMIT:   limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign raddr = (state_q == ST_P_RD) ? pvtx_q : src_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign dx_c     = 33'(cx_q) - 33'(signed'(rdata_q[31:0]));
	assign dy_c     = 33'(cy_q) - 33'(signed'(rdata_q[63:32]));
	assign sel_vtx  = (pidx_q == 3'd0) ? tgt_q : neg_q[pidx_q - 3'd1];
	assign f_c      = fh_q[59:0] + {36'd0, rsp.result[39:16]};
	assign prod_hi  = rsp.result[63:16];
	assign clip_c   = (prod_hi > {24'd0, limit_q}) ? limit_q : prod_hi[23:0];
	assign a_c      = rsp.result[40:16] == 25'd0 ? 26'sd0 :
	                  (((state_q == ST_AX) ? gxs_q : gys_q) ? -signed'({1'b0, rsp.result[40:16]})
	                                                       : signed'({1'b0, rsp.result[40:16]}));
	assign nx_c     = sat32(34'(px_q) - 34'(ax_q));
	assign ny_c     = sat32(34'(py_q) - 34'(ay_q));
	assign sx_c     = sat32(34'(signed'(rdata_q[31:0])) + 34'(ex_q));
	assign sy_c     = sat32(34'(signed'(rdata_q[63:32])) + 34'(ey_q));

	assign arith_go = (state_q == ST_P_CAP) ||
	                  (rsp.done && (state_q inside {ST_SQX, ST_SQY, ST_FH, ST_FL, ST_T1,
	                                                ST_G, ST_GX, ST_GY, ST_AX}));

	always_comb begin
		we    = 1'b0;
		waddr = pvtx_q;
		wdata = {ny_c, nx_c};
		case (state_q)
			ST_LOAD: begin
				we    = out_free;
				waddr = src_q;
				wdata = {load_y_q, load_x_q};
			end
			ST_P_WR: begin
				we    = out_free;
				waddr = pvtx_q;
				wdata = {ny_c, nx_c};
			end
			ST_FIN_WR: begin
				we    = out_free;
				waddr = src_q;
				wdata = {sy_c, sx_c};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			src_q    <= s_axis_tdata[11:0];
			tgt_q    <= s_axis_tdata[23:12];
			neg_q    <= s_axis_tdata[83:24];
			alpha_q  <= s_axis_tdata[99:84];
			load_x_q <= s_axis_tdata[131:100];
			load_y_q <= s_axis_tdata[163:132];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			req_q.start <= 1'b0;
			pidx_q      <= '0;
		end else begin
			req_q.start <= arith_go;
			if (we)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid)
						state_q <= s_axis_tuser ? ST_SRC_RD : ST_LOAD;
				end
				ST_LOAD: begin
					if (out_free) begin
						out_last_q   <= 1'b1;
						out_vertex_q <= src_q;
						out_x_q      <= load_x_q;
						out_y_q      <= load_y_q;
						state_q      <= ST_IDLE;
					end
				end
				ST_SRC_RD: state_q <= ST_SRC_CAP;
				ST_SRC_CAP: begin
					cx_q    <= rdata_q[31:0];
					cy_q    <= rdata_q[63:32];
					ex_q    <= '0;
					ey_q    <= '0;
					pidx_q  <= '0;
					state_q <= ST_SEL;
				end
				ST_SEL: begin
					if (pidx_q > 3'(eegu_pkg::NEGATIVES)) begin
						state_q <= ST_FIN_RD;
					end else if (pidx_q != 3'd0 && sel_vtx == tgt_q) begin
						pidx_q <= pidx_q + 3'd1;
					end else begin
						pvtx_q  <= sel_vtx;
						state_q <= ST_P_RD;
					end
				end
				ST_P_RD: state_q <= ST_P_CAP;
				ST_P_CAP: begin
					px_q        <= rdata_q[31:0];
					py_q        <= rdata_q[63:32];
					dxn_q       <= dx_c[32];
					dyn_q       <= dy_c[32];
					dxm_q       <= dx_c[32] ? 32'(-dx_c) : dx_c[31:0];
					dym_q       <= dy_c[32] ? 32'(-dy_c) : dy_c[31:0];
					req_q.op    <= eegu_pkg::OP_MUL;
					req_q.a     <= {32'd0, dx_c[32] ? 32'(-dx_c) : dx_c[31:0]};
					req_q.b     <= {32'd0, dx_c[32] ? 32'(-dx_c) : dx_c[31:0]};
					state_q     <= ST_SQX;
				end
				ST_SQX: begin
					if (rsp.done) begin
						sqx_q       <= prod_hi;
						req_q.op    <= eegu_pkg::OP_MUL;
						req_q.a     <= {32'd0, dym_q};
						req_q.b     <= {32'd0, dym_q};
						state_q     <= ST_SQY;
					end
				end
				ST_SQY: begin
					if (rsp.done) begin
						sq_q        <= {1'b0, sqx_q} + {1'b0, prod_hi};
						req_q.op    <= eegu_pkg::OP_MUL;
						req_q.a     <= {31'd0, 33'(({1'b0, sqx_q} + {1'b0, prod_hi}) >> 16)};
						req_q.b     <= {40'd0, scale_q};
						state_q     <= ST_FH;
					end
				end
				ST_FH: begin
					if (rsp.done) begin
						fh_q        <= rsp.result;
						req_q.op    <= eegu_pkg::OP_MUL;
						req_q.a     <= {48'd0, sq_q[15:0]};
						req_q.b     <= {40'd0, scale_q};
						state_q     <= ST_FL;
					end
				end
				ST_FL: begin
					if (rsp.done) begin
						f_q         <= f_c;
						req_q.op    <= eegu_pkg::OP_DIV;
						req_q.b     <= {4'd0, f_c + eegu_pkg::ONE_Q16};
						if (pidx_q == 3'd0) begin
							req_q.a <= 64'd1 << 33;
							state_q <= ST_G;
						end else begin
							req_q.a <= {23'd0, gamma_q, 17'd0};
							state_q <= ST_T1;
						end
					end
				end
				ST_T1: begin
					if (rsp.done) begin
						req_q.op    <= eegu_pkg::OP_DIV;
						req_q.a     <= {22'd0, rsp.result[25:0], 16'd0};
						req_q.b     <= {4'd0, f_q + eegu_pkg::TENTH_Q16};
						state_q     <= ST_G;
					end
				end
				ST_G: begin
					if (rsp.done) begin
						gmag_q      <= rsp.result[28:0];
						gneg_q      <= (pidx_q == 3'd0);
						req_q.op    <= eegu_pkg::OP_MUL;
						req_q.a     <= {35'd0, rsp.result[28:0]};
						req_q.b     <= {32'd0, dxm_q};
						state_q     <= ST_GX;
					end
				end
				ST_GX: begin
					if (rsp.done) begin
						gxm_q       <= clip_c;
						gxs_q       <= gneg_q ^ dxn_q;
						req_q.op    <= eegu_pkg::OP_MUL;
						req_q.a     <= {35'd0, gmag_q};
						req_q.b     <= {32'd0, dym_q};
						state_q     <= ST_GY;
					end
				end
				ST_GY: begin
					if (rsp.done) begin
						gym_q       <= clip_c;
						gys_q       <= gneg_q ^ dyn_q;
						req_q.op    <= eegu_pkg::OP_MUL;
						req_q.a     <= {40'd0, gxm_q};
						req_q.b     <= {48'd0, alpha_q};
						state_q     <= ST_AX;
					end
				end
				ST_AX: begin
					if (rsp.done) begin
						ax_q        <= a_c;
						req_q.op    <= eegu_pkg::OP_MUL;
						req_q.a     <= {40'd0, gym_q};
						req_q.b     <= {48'd0, alpha_q};
						state_q     <= ST_AY;
					end
				end
				ST_AY: begin
					if (rsp.done) begin
						ay_q    <= a_c;
						state_q <= ST_P_WR;
					end
				end
				ST_P_WR: begin
					if (out_free) begin
						out_last_q   <= 1'b0;
						out_vertex_q <= pvtx_q;
						out_x_q      <= nx_c;
						out_y_q      <= ny_c;
						ex_q         <= ex_q + 28'(ax_q);
						ey_q         <= ey_q + 28'(ay_q);
						pidx_q       <= pidx_q + 3'd1;
						state_q      <= ST_SEL;
					end
				end
				ST_FIN_RD: state_q <= ST_FIN_WR;
				ST_FIN_WR: begin
					if (out_free) begin
						out_last_q   <= 1'b1;
						out_vertex_q <= src_q;
						out_x_q      <= sx_c;
						out_y_q      <= sy_c;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	property p_write_gives_result;
		@(posedge clk) disable iff (!arst_n) we |=> m_axis_tvalid;
	endproperty
	a_write_gives_result: assert property (p_write_gives_result)
		else $error("memory write without a result");

	property p_start_is_pulse;
		@(posedge clk) disable iff (!arst_n) req_q.start |=> !req_q.start;
	endproperty
	a_start_is_pulse: assert property (p_start_is_pulse)
		else $error("arith start held for more than one cycle");

	property p_partner_index;
		@(posedge clk) disable iff (!arst_n) pidx_q <= 3'(eegu_pkg::NEGATIVES + 1);
	endproperty
	a_partner_index: assert property (p_partner_index)
		else $error("partner index out of range");

endmodule

[hw/rtl/eegu_arith.sv]
// Shared iterative unit: shift-add multiplier and restoring divider, one bit per cycle.
module eegu_arith (
	input  logic               clk,
	input  logic               arst_n,
	input  eegu_pkg::arith_req_t req,
	output eegu_pkg::arith_rsp_t rsp
);

	logic                busy_q;
	logic [5:0]          cnt_q;
	eegu_pkg::arith_op_t op_q;
	logic [63:0]         x_q;
	logic [63:0]         y_q;
	logic [63:0]         z_q;
	logic                done_q;
	logic [63:0]         rem_next;
	logic                qbit;

	assign rem_next = {z_q[62:0], y_q[eegu_pkg::DIV_STEPS-1]};
	assign qbit     = (rem_next >= x_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= (req.op == eegu_pkg::OP_MUL) ? 6'(eegu_pkg::MUL_STEPS)
				                                       : 6'(eegu_pkg::DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q <= req.op;
			x_q  <= (req.op == eegu_pkg::OP_MUL) ? req.a : req.b;
			y_q  <= (req.op == eegu_pkg::OP_MUL) ? {32'd0, req.b[31:0]} : req.a;
			z_q  <= '0;
		end else if (busy_q) begin
			if (op_q == eegu_pkg::OP_MUL) begin
				if (y_q[0])
					z_q <= z_q + x_q;
				x_q <= {x_q[62:0], 1'b0};
				y_q <= {1'b0, y_q[63:1]};
			end else begin
				z_q <= qbit ? rem_next - x_q : rem_next;
				y_q <= {y_q[62:0], qbit};
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = (op_q == eegu_pkg::OP_MUL) ? z_q
	                    : {22'd0, y_q[eegu_pkg::DIV_STEPS-1:0]};

	property p_no_start_when_busy;
		@(posedge clk) disable iff (!arst_n) req.start |-> !busy_q;
	endproperty
	a_no_start_when_busy: assert property (p_no_start_when_busy)
		else $error("arith unit started while busy");

	property p_done_after_busy;
		@(posedge clk) disable iff (!arst_n) done_q |-> !busy_q && $past(busy_q);
	endproperty
	a_done_after_busy: assert property (p_done_after_busy)
		else $error("arith done without a finished operation");

	property p_count_bounded;
		@(posedge clk) disable iff (!arst_n)
			busy_q |-> cnt_q != 6'd0 && cnt_q <= 6'(eegu_pkg::DIV_STEPS);
	endproperty
	a_count_bounded: assert property (p_count_bounded)
		else $error("arith step count out of range");

endmodule
